// File: rtl/opr_pkg.sv
// Package for the operator and punctuation recognizer.
// Holds the character codes, token codes and the decode result type.
// No dependencies.
`timescale 1ns / 1ps

package opr_pkg;

  // Input character codes (ASCII)
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_TILDE  = 8'h7E;

  // Token codes
  localparam logic [7:0] TK_NONE        = 8'h00;
  localparam logic [7:0] TK_HASH        = 8'h01;
  localparam logic [7:0] TK_DOLLAR      = 8'h02;
  localparam logic [7:0] TK_DOLLAR2     = 8'h03;
  localparam logic [7:0] TK_BSLASH      = 8'h04;
  localparam logic [7:0] TK_NEWLINE     = 8'h05;
  localparam logic [7:0] TK_NOT         = 8'h80;
  localparam logic [7:0] TK_NE          = 8'h81;
  localparam logic [7:0] TK_MOD         = 8'h82;
  localparam logic [7:0] TK_AND         = 8'h83;
  localparam logic [7:0] TK_LAND        = 8'h84;
  localparam logic [7:0] TK_LPAREN      = 8'h85;
  localparam logic [7:0] TK_RPAREN      = 8'h86;
  localparam logic [7:0] TK_MUL         = 8'h87;
  localparam logic [7:0] TK_ADD         = 8'h88;
  localparam logic [7:0] TK_INC         = 8'h89;
  localparam logic [7:0] TK_COMMA       = 8'h8B;
  localparam logic [7:0] TK_SUB         = 8'h8C;
  localparam logic [7:0] TK_DEC         = 8'h8D;
  localparam logic [7:0] TK_ARROW       = 8'h8F;
  localparam logic [7:0] TK_DOT         = 8'h90;
  localparam logic [7:0] TK_ELLIPSIS    = 8'h91;
  localparam logic [7:0] TK_DIV         = 8'h92;
  localparam logic [7:0] TK_COLON       = 8'h93;
  localparam logic [7:0] TK_SEMI        = 8'h94;
  localparam logic [7:0] TK_LT          = 8'h95;
  localparam logic [7:0] TK_SHL         = 8'h96;
  localparam logic [7:0] TK_LE          = 8'h97;
  localparam logic [7:0] TK_ASSIGN      = 8'h98;
  localparam logic [7:0] TK_MOD_ASSIGN  = 8'h99;
  localparam logic [7:0] TK_AND_ASSIGN  = 8'h9A;
  localparam logic [7:0] TK_MUL_ASSIGN  = 8'h9B;
  localparam logic [7:0] TK_ADD_ASSIGN  = 8'h9C;
  localparam logic [7:0] TK_SUB_ASSIGN  = 8'h9D;
  localparam logic [7:0] TK_DIV_ASSIGN  = 8'h9E;
  localparam logic [7:0] TK_SHL_ASSIGN  = 8'h9F;
  localparam logic [7:0] TK_EQ          = 8'hA0;
  localparam logic [7:0] TK_SHR_ASSIGN  = 8'hA1;
  localparam logic [7:0] TK_XOR_ASSIGN  = 8'hA2;
  localparam logic [7:0] TK_OR_ASSIGN   = 8'hA3;
  localparam logic [7:0] TK_GT          = 8'hA4;
  localparam logic [7:0] TK_GE          = 8'hA5;
  localparam logic [7:0] TK_SHR         = 8'hA6;
  localparam logic [7:0] TK_QUEST       = 8'hA7;
  localparam logic [7:0] TK_LBRACK      = 8'hA8;
  localparam logic [7:0] TK_RBRACK      = 8'hA9;
  localparam logic [7:0] TK_XOR         = 8'hAA;
  localparam logic [7:0] TK_LBRACE      = 8'hAB;
  localparam logic [7:0] TK_OR          = 8'hAC;
  localparam logic [7:0] TK_LOR         = 8'hAD;
  localparam logic [7:0] TK_RBRACE      = 8'hAE;
  localparam logic [7:0] TK_TILDE       = 8'hAF;

  // Token lengths
  localparam logic [1:0] LEN_NONE = 2'd0;
  localparam logic [1:0] LEN_ONE  = 2'd1;
  localparam logic [1:0] LEN_TWO  = 2'd2;
  localparam logic [1:0] LEN_THREE = 2'd3;

  // Width of the line number port
  localparam int unsigned LINE_OUT_BITS = 16;

  // Decoder result
  typedef struct packed {
    logic       matched;
    logic       newline;
    logic [7:0] code;
    logic [1:0] length;
  } tok_t;

endpackage

// File: rtl/operator_punctuation_recognizer_unit.sv
// Operator and punctuation recognizer, top level.
// Input register, token decoder and line counter, result register.
// Depends on opr_pkg, opr_decode, opr_line_counter.
//
// Usage:
//   Input channel (in_valid / in_stall) carries a three-byte window
//   first_byte, second_byte, third_byte and a start_of_text flag.
//   Output channel (out_valid / out_stall) carries matched, token_code,
//   token_length and line_number for each request, in order.
//   An accepted request first waits in the input register, then moves into
//   the result register once the output is free. The unit takes one request
//   per cycle while the output is not stalled; decode is a single
//   combinational pass between those two registers.
//   The line counter updates as a request moves into the result register,
//   so results always reflect requests in acceptance order.
//   When out_stall holds a result, the request in the input register waits
//   and in_stall rises; no request is dropped or duplicated.
//   Reset (rst, synchronous) empties both registers and sets the line
//   counter to 1.
`timescale 1ns / 1ps

module operator_punctuation_recognizer_unit #(
  parameter int unsigned LINE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  first_byte,
  input  logic [7:0]  second_byte,
  input  logic [7:0]  third_byte,
  input  logic        start_of_text,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        matched,
  output logic [7:0]  token_code,
  output logic [1:0]  token_length,
  output logic [15:0] line_number
);

  logic          s1_valid;
  logic [7:0]    s1_c0;
  logic [7:0]    s1_c1;
  logic [7:0]    s1_c2;
  logic          s1_start;
  logic          out_free;
  logic          s1_advance;
  logic          in_take;
  opr_pkg::tok_t tok;
  logic [15:0]   line_next_low;

  // Handshake control
  assign out_free   = !out_valid || !out_stall;
  assign s1_advance = s1_valid && out_free;
  assign in_stall   = s1_valid && !out_free;
  assign in_take    = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_c0    <= first_byte;
      s1_c1    <= second_byte;
      s1_c2    <= third_byte;
      s1_start <= start_of_text;
    end
  end

  // Token decode
  opr_decode u_decode (
    .c0  (s1_c0),
    .c1  (s1_c1),
    .c2  (s1_c2),
    .tok (tok)
  );

  // Line counter
  opr_line_counter #(
    .LINE_BITS (LINE_BITS)
  ) u_line_counter (
    .clk           (clk),
    .rst           (rst),
    .advance       (s1_advance),
    .start         (s1_start),
    .newline       (tok.newline),
    .line_next_low (line_next_low)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      matched      <= tok.matched;
      token_code   <= tok.code;
      token_length <= tok.length;
      line_number  <= line_next_low;
    end
  end

endmodule

// File: rtl/opr_decode.sv
// Token decoder: longest operator, punctuation or newline token at the
// first byte of a three-byte window. Pure combinational. Uses opr_pkg.
`timescale 1ns / 1ps

module opr_decode (
  input  logic [7:0]   c0,
  input  logic [7:0]   c1,
  input  logic [7:0]   c2,
  output opr_pkg::tok_t tok
);

  logic [7:0] code;
  logic [1:0] len;

  // Maximal munch over the lookahead bytes
  always_comb begin
    code = opr_pkg::TK_NONE;
    len  = opr_pkg::LEN_NONE;
    unique case (c0)
      opr_pkg::CH_LF: begin
        code = opr_pkg::TK_NEWLINE; len = opr_pkg::LEN_ONE;
      end
      opr_pkg::CH_CR: begin
        code = opr_pkg::TK_NEWLINE;
        len  = (c1 == opr_pkg::CH_LF) ? opr_pkg::LEN_TWO : opr_pkg::LEN_ONE;
      end
      opr_pkg::CH_BANG: begin
        if (c1 == opr_pkg::CH_EQ) begin
          code = opr_pkg::TK_NE; len = opr_pkg::LEN_TWO;
        end else begin
          code = opr_pkg::TK_NOT; len = opr_pkg::LEN_ONE;
        end
      end
      opr_pkg::CH_HASH: begin
        code = opr_pkg::TK_HASH; len = opr_pkg::LEN_ONE;
      end
      opr_pkg::CH_DOLLAR: begin
        if (c1 == opr_pkg::CH_DOLLAR) begin
          code = opr_pkg::TK_DOLLAR2; len = opr_pkg::LEN_TWO;
        end else begin
          code = opr_pkg::TK_DOLLAR; len = opr_pkg::LEN_ONE;
        end
      end
      opr_pkg::CH_PCT: begin
        if (c1 == opr_pkg::CH_EQ) begin
          code = opr_pkg::TK_MOD_ASSIGN; len = opr_pkg::LEN_TWO;
        end else begin
          code = opr_pkg::TK_MOD; len = opr_pkg::LEN_ONE;
        end
      end
      opr_pkg::CH_AMP: begin
        if (c1 == opr_pkg::CH_AMP) begin
          code = opr_pkg::TK_LAND; len = opr_pkg::LEN_TWO;
        end else if (c1 == opr_pkg::CH_EQ) begin
          code = opr_pkg::TK_AND_ASSIGN; len = opr_pkg::LEN_TWO;
        end else begin
          code = opr_pkg::TK_AND; len = opr_pkg::LEN_ONE;
        end
      end
      opr_pkg::CH_LPAREN: begin
        code = opr_pkg::TK_LPAREN; len = opr_pkg::LEN_ONE;
      end
      opr_pkg::CH_RPAREN: begin
        code = opr_pkg::TK_RPAREN; len = opr_pkg::LEN_ONE;
      end
      opr_pkg::CH_STAR: begin
        if (c1 == opr_pkg::CH_EQ) begin
          code = opr_pkg::TK_MUL_ASSIGN; len = opr_pkg::LEN_TWO;
        end else begin
          code = opr_pkg::TK_MUL; len = opr_pkg::LEN_ONE;
        end
      end
      opr_pkg::CH_PLUS: begin
        if (c1 == opr_pkg::CH_PLUS) begin
          code = opr_pkg::TK_INC; len = opr_pkg::LEN_TWO;
        end else if (c1 == opr_pkg::CH_EQ) begin
          code = opr_pkg::TK_ADD_ASSIGN; len = opr_pkg::LEN_TWO;
        end else begin
          code = opr_pkg::TK_ADD; len = opr_pkg::LEN_ONE;
        end
      end
      opr_pkg::CH_COMMA: begin
        code = opr_pkg::TK_COMMA; len = opr_pkg::LEN_ONE;
      end
      opr_pkg::CH_MINUS: begin
        if (c1 == opr_pkg::CH_MINUS) begin
          code = opr_pkg::TK_DEC; len = opr_pkg::LEN_TWO;
        end else if (c1 == opr_pkg::CH_EQ) begin
          code = opr_pkg::TK_SUB_ASSIGN; len = opr_pkg::LEN_TWO;
        end else if (c1 == opr_pkg::CH_GT) begin
          code = opr_pkg::TK_ARROW; len = opr_pkg::LEN_TWO;
        end else begin
          code = opr_pkg::TK_SUB; len = opr_pkg::LEN_ONE;
        end
      end
      opr_pkg::CH_DOT: begin
        if (c1 == opr_pkg::CH_DOT && c2 == opr_pkg::CH_DOT) begin
          code = opr_pkg::TK_ELLIPSIS; len = opr_pkg::LEN_THREE;
        end else begin
          code = opr_pkg::TK_DOT; len = opr_pkg::LEN_ONE;
        end
      end
      opr_pkg::CH_SLASH: begin
        if (c1 == opr_pkg::CH_EQ) begin
          code = opr_pkg::TK_DIV_ASSIGN; len = opr_pkg::LEN_TWO;
        end else begin
          code = opr_pkg::TK_DIV; len = opr_pkg::LEN_ONE;
        end
      end
      opr_pkg::CH_COLON: begin
        code = opr_pkg::TK_COLON; len = opr_pkg::LEN_ONE;
      end
      opr_pkg::CH_SEMI: begin
        code = opr_pkg::TK_SEMI; len = opr_pkg::LEN_ONE;
      end
      opr_pkg::CH_LT: begin
        if (c1 == opr_pkg::CH_LT && c2 == opr_pkg::CH_EQ) begin
          code = opr_pkg::TK_SHL_ASSIGN; len = opr_pkg::LEN_THREE;
        end else if (c1 == opr_pkg::CH_LT) begin
          code = opr_pkg::TK_SHL; len = opr_pkg::LEN_TWO;
        end else if (c1 == opr_pkg::CH_EQ) begin
          code = opr_pkg::TK_LE; len = opr_pkg::LEN_TWO;
        end else begin
          code = opr_pkg::TK_LT; len = opr_pkg::LEN_ONE;
        end
      end
      opr_pkg::CH_EQ: begin
        if (c1 == opr_pkg::CH_EQ) begin
          code = opr_pkg::TK_EQ; len = opr_pkg::LEN_TWO;
        end else begin
          code = opr_pkg::TK_ASSIGN; len = opr_pkg::LEN_ONE;
        end
      end
      opr_pkg::CH_GT: begin
        if (c1 == opr_pkg::CH_GT && c2 == opr_pkg::CH_EQ) begin
          code = opr_pkg::TK_SHR_ASSIGN; len = opr_pkg::LEN_THREE;
        end else if (c1 == opr_pkg::CH_GT) begin
          code = opr_pkg::TK_SHR; len = opr_pkg::LEN_TWO;
        end else if (c1 == opr_pkg::CH_EQ) begin
          code = opr_pkg::TK_GE; len = opr_pkg::LEN_TWO;
        end else begin
          code = opr_pkg::TK_GT; len = opr_pkg::LEN_ONE;
        end
      end
      opr_pkg::CH_QUEST: begin
        code = opr_pkg::TK_QUEST; len = opr_pkg::LEN_ONE;
      end
      opr_pkg::CH_LBRACK: begin
        code = opr_pkg::TK_LBRACK; len = opr_pkg::LEN_ONE;
      end
      opr_pkg::CH_BSLASH: begin
        code = opr_pkg::TK_BSLASH; len = opr_pkg::LEN_ONE;
      end
      opr_pkg::CH_RBRACK: begin
        code = opr_pkg::TK_RBRACK; len = opr_pkg::LEN_ONE;
      end
      opr_pkg::CH_CARET: begin
        if (c1 == opr_pkg::CH_EQ) begin
          code = opr_pkg::TK_XOR_ASSIGN; len = opr_pkg::LEN_TWO;
        end else begin
          code = opr_pkg::TK_XOR; len = opr_pkg::LEN_ONE;
        end
      end
      opr_pkg::CH_LBRACE: begin
        code = opr_pkg::TK_LBRACE; len = opr_pkg::LEN_ONE;
      end
      opr_pkg::CH_PIPE: begin
        if (c1 == opr_pkg::CH_EQ) begin
          code = opr_pkg::TK_OR_ASSIGN; len = opr_pkg::LEN_TWO;
        end else if (c1 == opr_pkg::CH_PIPE) begin
          code = opr_pkg::TK_LOR; len = opr_pkg::LEN_TWO;
        end else begin
          code = opr_pkg::TK_OR; len = opr_pkg::LEN_ONE;
        end
      end
      opr_pkg::CH_RBRACE: begin
        code = opr_pkg::TK_RBRACE; len = opr_pkg::LEN_ONE;
      end
      opr_pkg::CH_TILDE: begin
        code = opr_pkg::TK_TILDE; len = opr_pkg::LEN_ONE;
      end
      default: begin
        code = opr_pkg::TK_NONE; len = opr_pkg::LEN_NONE;
      end
    endcase
  end

  assign tok.matched = (len != opr_pkg::LEN_NONE);
  assign tok.newline = (code == opr_pkg::TK_NEWLINE);
  assign tok.code    = code;
  assign tok.length  = len;

endmodule

// File: rtl/opr_line_counter.sv
// Saturating line counter: restart on start of text, count newline tokens.
// Gives the low bits of the updated count. Uses opr_pkg.
`timescale 1ns / 1ps

module opr_line_counter #(
  parameter int unsigned LINE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              advance,
  input  logic                              start,
  input  logic                              newline,
  output logic [opr_pkg::LINE_OUT_BITS-1:0] line_next_low
);

  localparam int unsigned ExtBits =
    (LINE_BITS > opr_pkg::LINE_OUT_BITS) ? LINE_BITS : opr_pkg::LINE_OUT_BITS;
  localparam logic [LINE_BITS-1:0] CountMax = {LINE_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0] CountOne = LINE_BITS'(1);

  logic [LINE_BITS-1:0] line_count;
  logic [LINE_BITS-1:0] line_count_next;
  logic [LINE_BITS-1:0] base;
  logic [ExtBits-1:0]   count_ext;

  // Restart first, then bump on a newline unless saturated
  always_comb begin
    base = start ? CountOne : line_count;
    if (newline && (base != CountMax)) begin
      line_count_next = base + CountOne;
    end else begin
      line_count_next = base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count <= CountOne;
    end else if (advance) begin
      line_count <= line_count_next;
    end
  end

  assign count_ext     = ExtBits'(line_count_next);
  assign line_next_low = count_ext[opr_pkg::LINE_OUT_BITS-1:0];

endmodule

// File: rtl/opr_checker.sv
// Port-level checks for the operator and punctuation recognizer.
// Bound to operator_punctuation_recognizer_unit. Uses opr_pkg.
`timescale 1ns / 1ps

module opr_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        matched,
  input logic [7:0]  token_code,
  input logic [1:0]  token_length,
  input logic [15:0] line_number
);

  // Match flag agrees with the length
  a_match_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (matched == (token_length != opr_pkg::LEN_NONE)))
    else $error("matched disagrees with token_length");

  // Unmatched results carry no code
  a_nomatch_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !matched) |-> (token_code == opr_pkg::TK_NONE))
    else $error("unmatched result has a token code");

  // Only the three long operators are three bytes
  a_three_byte: assert property (@(posedge clk) disable iff (rst)
    (out_valid && token_length == opr_pkg::LEN_THREE) |->
      (token_code == opr_pkg::TK_ELLIPSIS || token_code == opr_pkg::TK_SHL_ASSIGN ||
       token_code == opr_pkg::TK_SHR_ASSIGN))
    else $error("three-byte token with unexpected code");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(matched) && $stable(token_code) &&
       $stable(token_length) && $stable(line_number)))
    else $error("stalled result changed");

endmodule

bind operator_punctuation_recognizer_unit opr_checker u_opr_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .matched      (matched),
  .token_code   (token_code),
  .token_length (token_length),
  .line_number  (line_number)
);
